@@ hdl/ocs_pkg.sv @@
`default_nettype none

package ocs_pkg;

    localparam int unsigned DIST_W  = 16;
    localparam int unsigned TICK_W  = 10;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned SPEED_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TERRAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [DIST_W-1:0] TERRAIN_RST = 16'd5000;
    localparam logic [DIST_W-1:0] DETECT_RST  = 16'd5000;
    localparam logic [DIST_W-1:0] MARGIN_RST  = 16'd5000;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 10'd20;

    localparam logic [DIST_W:0]   MAX_CLEAR_MM    = 17'd50000;
    localparam logic [DIST_W-1:0] DESCENT_MM      = 16'd500;
    localparam logic [DIST_W-1:0] CRITICAL_MM     = 16'd2000;
    localparam logic [DIST_W-1:0] MIN_VALID_MM    = 16'd100;
    localparam logic [DIST_W-1:0] PANIC_MARGIN_MM = 16'd2000;
    localparam logic [DIST_W-1:0] EXTRA_CLIMB_MM  = 16'd1500;
    localparam logic [DIST_W-1:0] REACH_TOL_MM    = 16'd500;
    localparam logic [DIST_W-1:0] NO_OBSTACLE     = 16'hFFFF;
    localparam logic [DIST_W-1:0] MIN_PARAM_MM    = 16'd2000;

    localparam logic [SPEED_W-1:0] SPEED_FULL = 2'd0;
    localparam logic [SPEED_W-1:0] SPEED_SLOW = 2'd1;
    localparam logic [SPEED_W-1:0] SPEED_STOP = 2'd2;

    typedef struct packed {
        logic [DIST_W-1:0]  target_altitude_mm;
        logic [SPEED_W-1:0] speed_mode;
        logic               panic_climb;
        logic               emergency_active;
    } t_result;

    function automatic logic [DIST_W-1:0] cap_clear(input logic [DIST_W:0] v);
        logic [DIST_W:0] c;
        c = (v > MAX_CLEAR_MM) ? MAX_CLEAR_MM : v;
        return c[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] at_least_min(input logic [DIST_W-1:0] v);
        return (v < MIN_PARAM_MM) ? MIN_PARAM_MM : v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/obstacle_climb_supervisor_unit.sv @@
// obstacle climb supervisor
// input channel: i_valid / o_stall carry one control tick (sonar, obstacle
// distance, descent request); a transaction is taken when i_valid is high
// and o_stall is low
// output channel: o_valid / i_stall carry one result per tick (target
// altitude, speed mode, panic and emergency flags)
// configuration: i_cfg_valid / o_cfg_ready with register index and data;
// o_cfg_ready is always high, write only while the block is idle
// the result is registered; throughput is one tick per cycle while o_stall
// is low, set by the single compare-and-add stage that updates the
// supervisor state
// a two-entry output stage (result register plus skid register) lets one
// more tick in while a result waits; o_stall rises only when both are full
// reset: flags, clearance altitude and tick count go to zero, the
// registers to their defaults, and both output entries empty
// on a downstream stall the held result stays unchanged on the outputs
`default_nettype none

module obstacle_climb_supervisor_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [ocs_pkg::DIST_W-1:0]        i_sonar_mm,
    input  wire logic [ocs_pkg::DIST_W-1:0]        i_obstacle_mm,
    input  wire logic                              i_allow_descent,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [ocs_pkg::DIST_W-1:0]             o_target_altitude_mm,
    output logic [ocs_pkg::SPEED_W-1:0]            o_speed_mode,
    output logic                                   o_panic_climb,
    output logic                                   o_emergency_active,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ocs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ocs_pkg::DIST_W-1:0]        i_cfg_data
);

    logic [ocs_pkg::DIST_W-1:0]  r_terrain;
    logic [ocs_pkg::DIST_W-1:0]  r_detect;
    logic [ocs_pkg::DIST_W-1:0]  r_margin;
    logic [ocs_pkg::TICK_W-1:0]  r_timeout;

    logic                        r_emergency, n_emergency;
    logic                        r_hold, n_hold;
    logic                        r_panic, n_panic;
    logic [ocs_pkg::DIST_W-1:0]  r_clear, n_clear;
    logic [ocs_pkg::COUNT_W-1:0] r_ticks, n_ticks;

    ocs_pkg::t_result r_out, r_skid, n_result;
    logic             r_out_valid, r_skid_valid;

    logic in_take, out_take;
    logic detected, cleared;
    logic [18:0] obst_x5, detect_x6;
    logic [ocs_pkg::DIST_W:0] sum_margin, sum_panic, sum_extra, sum_reach;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skid_valid;
    assign in_take     = i_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_stall;

    assign o_valid              = r_out_valid;
    assign o_target_altitude_mm = r_out.target_altitude_mm;
    assign o_speed_mode         = r_out.speed_mode;
    assign o_panic_climb        = r_out.panic_climb;
    assign o_emergency_active   = r_out.emergency_active;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terrain <= ocs_pkg::TERRAIN_RST;
            r_detect  <= ocs_pkg::DETECT_RST;
            r_margin  <= ocs_pkg::MARGIN_RST;
            r_timeout <= ocs_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ocs_pkg::CFG_TERRAIN: r_terrain <= i_cfg_data;
                ocs_pkg::CFG_DETECT:  r_detect  <= ocs_pkg::at_least_min(i_cfg_data);
                ocs_pkg::CFG_MARGIN:  r_margin  <= ocs_pkg::at_least_min(i_cfg_data);
                ocs_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[ocs_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign obst_x5    = {i_obstacle_mm, 2'b00} + {3'b000, i_obstacle_mm};
    assign detect_x6  = {1'b0, r_detect, 2'b00} + {2'b00, r_detect, 1'b0};
    assign sum_margin = {1'b0, i_sonar_mm} + {1'b0, r_margin};
    assign sum_panic  = {1'b0, i_sonar_mm} + {1'b0, ocs_pkg::PANIC_MARGIN_MM};
    assign sum_extra  = {1'b0, i_sonar_mm} + {1'b0, ocs_pkg::EXTRA_CLIMB_MM};
    assign sum_reach  = {1'b0, i_sonar_mm} + {1'b0, ocs_pkg::REACH_TOL_MM};

    assign detected = (i_obstacle_mm != ocs_pkg::NO_OBSTACLE) &&
                      (i_obstacle_mm < r_detect) &&
                      (i_obstacle_mm > ocs_pkg::MIN_VALID_MM);
    assign cleared  = (i_obstacle_mm == ocs_pkg::NO_OBSTACLE) || (obst_x5 > detect_x6);

    // one tick of supervisor state
    always_comb begin
        n_emergency = r_emergency;
        n_hold      = r_hold;
        n_panic     = r_panic;
        n_clear     = r_clear;
        n_ticks     = r_ticks;
        n_result.target_altitude_mm = r_terrain;
        n_result.speed_mode         = ocs_pkg::SPEED_FULL;

        if (r_emergency && (r_ticks != {ocs_pkg::COUNT_W{1'b1}})) begin
            n_ticks = r_ticks + {{(ocs_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end

        if (i_allow_descent) begin
            n_result.target_altitude_mm = ocs_pkg::DESCENT_MM;
        end else if (detected) begin
            n_result.speed_mode = (i_obstacle_mm < ocs_pkg::CRITICAL_MM) ?
                                  ocs_pkg::SPEED_STOP : ocs_pkg::SPEED_SLOW;
            if (!r_emergency) begin
                n_clear     = ocs_pkg::cap_clear(sum_margin);
                n_emergency = 1'b1;
                n_ticks     = '0;
                n_panic     = 1'b0;
                n_hold      = 1'b0;
            end
            if ((n_ticks > {{(ocs_pkg::COUNT_W-ocs_pkg::TICK_W){1'b0}}, r_timeout}) &&
                !n_panic) begin
                n_panic = 1'b1;
                n_clear = ocs_pkg::cap_clear(sum_panic);
            end
            n_result.target_altitude_mm = n_clear;
        end else if (r_emergency && cleared) begin
            if (!r_hold) begin
                n_clear = ocs_pkg::cap_clear(sum_extra);
                n_hold  = 1'b1;
            end
            if (sum_reach >= {1'b0, n_clear}) begin
                n_emergency = 1'b0;
                n_hold      = 1'b0;
                n_panic     = 1'b0;
                n_result.target_altitude_mm = r_terrain;
            end else begin
                n_result.target_altitude_mm = n_clear;
            end
        end else if (r_emergency) begin
            n_result.target_altitude_mm = r_clear;
            n_result.speed_mode         = ocs_pkg::SPEED_SLOW;
        end

        n_result.panic_climb      = n_panic;
        n_result.emergency_active = n_emergency;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emergency <= 1'b0;
            r_hold      <= 1'b0;
            r_panic     <= 1'b0;
            r_clear     <= '0;
            r_ticks     <= '0;
        end else if (in_take) begin
            r_emergency <= n_emergency;
            r_hold      <= n_hold;
            r_panic     <= n_panic;
            r_clear     <= n_clear;
            r_ticks     <= n_ticks;
        end
    end

    // result register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_take) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_take) begin
            if (r_out_valid && !out_take) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

endmodule

`default_nettype wire
